FILE: rtl/otsu_pkg.sv
// Shared types and constants of the Otsu threshold finder.
`timescale 1ns / 1ps
`default_nettype none
package otsu_pkg;

  // Width of a gray level and of the threshold result.
  localparam int LEVEL_BITS = 8;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One pixel item as it travels from the front to the back.
  typedef struct packed {
    logic [LEVEL_BITS-1:0] bin;
    logic                  last;
  } otsu_item_t;

endpackage
`default_nettype wire

FILE: rtl/otsu_front.sv
// Front part: accepts pixel items, clamps the level to a bin and pushes them to the queue.
`timescale 1ns / 1ps
`default_nettype none
module otsu_front import otsu_pkg::*; #(
  parameter int LEVELS = 256
) (
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [LEVEL_BITS-1:0] pixel_i,
  input  wire logic                  last_pixel_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output otsu_item_t                 q_item_o
);

  logic over;

  // Levels at or above the bin count fall into the top bin.
  assign over = {1'b0, pixel_i} >= (LEVEL_BITS + 1)'(LEVELS);

  assign in_stall_o    = q_full_i;
  assign q_push_o      = in_valid_i & ~q_full_i;
  assign q_item_o.bin  = over ? LEVEL_BITS'(LEVELS - 1) : pixel_i;
  assign q_item_o.last = last_pixel_i;

endmodule
`default_nettype wire

FILE: rtl/otsu_queue.sv
// Short item queue that decouples the front from the back.
`timescale 1ns / 1ps
`default_nettype none
module otsu_queue import otsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire otsu_item_t item_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output otsu_item_t      item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  otsu_item_t         slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/otsu_mul.sv
// Iterative shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module otsu_mul #(
  parameter int A_W = 157,
  parameter int B_W = 56
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [A_W-1:0] a_i,
  input  wire logic [B_W-1:0] b_i,
  output logic                done_o,
  output logic [A_W-1:0]      prod_o
);

  logic [A_W-1:0] a_q, acc_q;
  logic [B_W-1:0] b_q;
  logic           busy_q, done_q;

  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && b_q != '0) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/otsu_back.sv
// Back part: histogram memory update and the exact threshold search.
`timescale 1ns / 1ps
`default_nettype none
module otsu_back import otsu_pkg::*; #(
  parameter int LEVELS     = 256,
  parameter int COUNT_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  wire otsu_item_t            q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [LEVEL_BITS-1:0]      threshold_o
);

  localparam int IDX_W  = $clog2(LEVELS);
  localparam int N_W    = COUNT_BITS + LEVEL_BITS;
  localparam int S_W    = COUNT_BITS + 2 * LEVEL_BITS;
  localparam int SQ_W   = 2 * S_W;
  localparam int NUM_W  = SQ_W + N_W + 1;
  localparam int DEN_W  = 2 * N_W;
  localparam int PROD_W = NUM_W + DEN_W;

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_INC      = 14'b00000000000010,
    ST_SUM_RD   = 14'b00000000000100,
    ST_SUM_ACC  = 14'b00000000001000,
    ST_SCAN_RD  = 14'b00000000010000,
    ST_SCAN_ACC = 14'b00000000100000,
    ST_M_S0     = 14'b00000001000000,
    ST_M_A      = 14'b00000010000000,
    ST_M_S1     = 14'b00000100000000,
    ST_M_B      = 14'b00001000000000,
    ST_M_DEN    = 14'b00010000000000,
    ST_M_L      = 14'b00100000000000,
    ST_M_R      = 14'b01000000000000,
    ST_DONE     = 14'b10000000000000
  } otsu_state_e;

  otsu_state_e state_q, state_d;

  logic [COUNT_BITS-1:0] hist_mem [LEVELS];
  logic [LEVELS-1:0]     vld_q;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] cnt, cnt_inc;

  logic [IDX_W-1:0]      addr_q, k_q;
  logic                  last_q, issued_q;
  logic [N_W-1:0]        ntot_q, n0_q, n1, m0, m1;
  logic [S_W-1:0]        stot_q, s0_q, s1;
  logic [SQ_W-1:0]       sq_q;
  logic [NUM_W-1:0]      numa_q, num_q, best_num_q;
  logic [DEN_W-1:0]      den_q, best_den_q;
  logic [PROD_W-1:0]     lhs_q;
  logic [IDX_W-1:0]      best_level_q;
  logic                  out_valid_q;
  logic [LEVEL_BITS-1:0] thr_q;

  logic                  mul_start, mul_done, in_mul;
  logic [PROD_W-1:0]     mul_a, mul_prod;
  logic [DEN_W-1:0]      mul_b;

  otsu_mul #(.A_W(PROD_W), .B_W(DEN_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign cnt     = rd_vld_q ? rd_data_q : '0;
  assign cnt_inc = (cnt == '1) ? cnt : cnt + 1'b1;
  assign n1      = ntot_q - n0_q;
  assign s1      = stot_q - s0_q;
  // An empty class counts as one pixel of sum zero, so it adds nothing.
  assign m0      = (n0_q == '0) ? N_W'(1) : n0_q;
  assign m1      = (n1 == '0) ? N_W'(1) : n1;

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign rd_addr = (state_q == ST_IDLE) ? q_item_i.bin[IDX_W-1:0] : k_q;
  assign rd_en   = q_pop_o || state_q == ST_SUM_RD || state_q == ST_SCAN_RD;
  assign wr_en   = state_q == ST_INC;

  assign in_mul    = state_q == ST_M_S0 || state_q == ST_M_A || state_q == ST_M_S1 ||
                     state_q == ST_M_B || state_q == ST_M_DEN || state_q == ST_M_L ||
                     state_q == ST_M_R;
  assign mul_start = in_mul && !issued_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_M_S0:  begin mul_a = PROD_W'(s0_q);       mul_b = DEN_W'(s0_q);  end
      ST_M_A:   begin mul_a = PROD_W'(sq_q);       mul_b = DEN_W'(m1);    end
      ST_M_S1:  begin mul_a = PROD_W'(s1);         mul_b = DEN_W'(s1);    end
      ST_M_B:   begin mul_a = PROD_W'(sq_q);       mul_b = DEN_W'(m0);    end
      ST_M_DEN: begin mul_a = PROD_W'(m0);         mul_b = DEN_W'(m1);    end
      ST_M_L:   begin mul_a = PROD_W'(num_q);      mul_b = best_den_q;    end
      ST_M_R:   begin mul_a = PROD_W'(best_num_q); mul_b = den_q;         end
      default:  begin mul_a = '0;                  mul_b = '0;            end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (q_valid_i) state_d = ST_INC;
      ST_INC:      state_d = last_q ? ST_SUM_RD : ST_IDLE;
      ST_SUM_RD:   state_d = ST_SUM_ACC;
      ST_SUM_ACC:  state_d = (k_q == IDX_W'(LEVELS - 1)) ? ST_SCAN_RD : ST_SUM_RD;
      ST_SCAN_RD:  state_d = ST_SCAN_ACC;
      ST_SCAN_ACC: state_d = ST_M_S0;
      ST_M_S0:     if (issued_q && mul_done) state_d = ST_M_A;
      ST_M_A:      if (issued_q && mul_done) state_d = ST_M_S1;
      ST_M_S1:     if (issued_q && mul_done) state_d = ST_M_B;
      ST_M_B:      if (issued_q && mul_done) state_d = ST_M_DEN;
      ST_M_DEN:    if (issued_q && mul_done) state_d = ST_M_L;
      ST_M_L:      if (issued_q && mul_done) state_d = ST_M_R;
      ST_M_R: begin
        if (issued_q && mul_done) begin
          state_d = (k_q == IDX_W'(LEVELS - 1)) ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_DONE:     if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Histogram memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
    if (wr_en) begin
      hist_mem[addr_q] <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (wr_en) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (mul_start) begin
        issued_q <= 1'b1;
      end else if (mul_done) begin
        issued_q <= 1'b0;
      end
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INC:     k_q <= '0;
        ST_SUM_ACC: k_q <= (k_q == IDX_W'(LEVELS - 1)) ? '0 : k_q + 1'b1;
        ST_M_R:     if (issued_q && mul_done) k_q <= k_q + 1'b1;
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            vld_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        addr_q <= q_item_i.bin[IDX_W-1:0];
        last_q <= q_item_i.last;
      end
      ST_INC: begin
        ntot_q     <= '0;
        stot_q     <= '0;
        n0_q       <= '0;
        s0_q       <= '0;
        // The best score starts each search as zero over one.
        best_num_q <= '0;
        best_den_q <= DEN_W'(1);
      end
      ST_SUM_ACC: begin
        ntot_q <= ntot_q + N_W'(cnt);
        stot_q <= stot_q + S_W'(cnt) * S_W'(k_q);
      end
      ST_SCAN_ACC: begin
        n0_q <= n0_q + N_W'(cnt);
        s0_q <= s0_q + S_W'(cnt) * S_W'(k_q);
      end
      ST_M_S0:  if (issued_q && mul_done) sq_q   <= mul_prod[SQ_W-1:0];
      ST_M_A:   if (issued_q && mul_done) numa_q <= mul_prod[NUM_W-1:0];
      ST_M_S1:  if (issued_q && mul_done) sq_q   <= mul_prod[SQ_W-1:0];
      ST_M_B:   if (issued_q && mul_done) num_q  <= numa_q + mul_prod[NUM_W-1:0];
      ST_M_DEN: if (issued_q && mul_done) den_q  <= mul_prod[DEN_W-1:0];
      ST_M_L:   if (issued_q && mul_done) lhs_q  <= mul_prod;
      ST_M_R: begin
        // Strict compare keeps the first of equal scores.
        if (issued_q && mul_done && (k_q == '0 || lhs_q > mul_prod)) begin
          best_num_q   <= num_q;
          best_den_q   <= den_q;
          best_level_q <= k_q;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          thr_q <= LEVEL_BITS'(best_level_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign threshold_o = thr_q;

endmodule
`default_nettype wire

FILE: rtl/otsu_threshold_finder_top.sv
// Top level of the Otsu threshold finder: front, queue and back joined.
//
//  Channel  Signals                               Dir  Meaning
//  input    in_valid_i, in_stall_o,               in   one pixel item per handshake
//           pixel_i[7:0], last_pixel_i
//  output   out_valid_o, out_stall_i,             out  one threshold item per image
//           threshold_o[7:0]
//
// The back reads the histogram memory for each pixel item in ST_IDLE and
// writes the incremented bin back in ST_INC; the front queue accepts
// items at one per cycle until its two entries are full.
// After the last pixel the search reads every bin once for the totals, then for
// each threshold reads and adds in one bin and makes seven passes of the bit-serial
// multiplier, each of which runs until its multiplier operand has shifted to zero.
// Reset clears the bin valid flags at once, so no clearing pass is needed.
// A result waits in the output register while the back already counts the next
// image; only a second answer is held back until the first has been taken.
`timescale 1ns / 1ps
`default_nettype none
module otsu_threshold_finder_top import otsu_pkg::*; #(
  parameter int LEVELS     = 256,
  parameter int COUNT_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [LEVEL_BITS-1:0] pixel_i,
  input  wire logic                  last_pixel_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [LEVEL_BITS-1:0]      threshold_o
);

  logic       q_full, q_push, q_pop, q_valid;
  otsu_item_t push_item, pop_item;

  // The front clamps each level to a bin and queues the item.
  otsu_front #(.LEVELS(LEVELS)) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .last_pixel_i (last_pixel_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  otsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  // The back owns the histogram and runs the search after the last pixel.
  otsu_back #(.LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .threshold_o (threshold_o)
  );

endmodule
`default_nettype wire

FILE: dv/otsu_threshold_finder_top_tb.sv
// Self-checking testbench of the Otsu threshold finder top level.
`timescale 1ns / 1ps
`default_nettype none
module otsu_threshold_finder_top_tb import otsu_pkg::*;;

  localparam int NUM_LEVELS   = 256;
  localparam int COUNT_W      = 20;
  localparam int STALL_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [LEVEL_BITS-1:0] pixel_i = '0;
  logic                  last_pixel_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LEVEL_BITS-1:0] threshold_o;

  otsu_threshold_finder_top #(
    .LEVELS    (NUM_LEVELS),
    .COUNT_BITS(COUNT_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .last_pixel_i(last_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .threshold_o (threshold_o)
  );

  // The clock runs with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Our own copy of the histogram, updated on every accepted pixel item.
  int unsigned           hist_bins [NUM_LEVELS];
  logic [LEVEL_BITS-1:0] thresholds_due [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned images_sent = 0;
  int unsigned thresholds_seen = 0;
  int unsigned quiet_cycles = 0;

  // Search every threshold and keep the one with the largest
  // S0^2/n0 + S1^2/n1. Fractions are compared by cross multiplication, so
  // wide vectors keep everything exact. An empty class contributes nothing,
  // and a strict comparison lets the first of equal scores stand.
  function automatic logic [LEVEL_BITS-1:0] best_threshold();
    logic [191:0]          n_all, s_all, n0, s0, n1, s1;
    logic [191:0]          num, den, best_num, best_den;
    logic [LEVEL_BITS-1:0] best_k;
    n_all = '0;
    s_all = '0;
    n0 = '0;
    s0 = '0;
    best_num = '0;
    best_den = 192'd1;
    best_k = '0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      n_all += hist_bins[k];
      s_all += 192'(hist_bins[k]) * 192'(k);
    end
    for (int k = 0; k < NUM_LEVELS; k++) begin
      n0 += hist_bins[k];
      s0 += 192'(hist_bins[k]) * 192'(k);
      n1 = n_all - n0;
      s1 = s_all - s0;
      if (n0 != 0 && n1 != 0) begin
        num = s0 * s0 * n1 + s1 * s1 * n0;
        den = n0 * n1;
      end else if (n0 != 0) begin
        num = s0 * s0;
        den = n0;
      end else if (n1 != 0) begin
        num = s1 * s1;
        den = n1;
      end else begin
        num = '0;
        den = 192'd1;
      end
      if (k == 0 || num * best_den > best_num * den) begin
        best_num = num;
        best_den = den;
        best_k = LEVEL_BITS'(k);
      end
    end
    return best_k;
  endfunction

  // Offer one pixel item and wait until it is taken. The sender may idle
  // for a cycle first; otherwise valid stays high across back-to-back items.
  task automatic send_pixel(input logic [LEVEL_BITS-1:0] level, input logic last);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_i      <= level;
    last_pixel_i <= last;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        // Counts saturate, though no image here gets near the limit.
        if (hist_bins[level] < (1 << COUNT_W) - 1) hist_bins[level]++;
        pixels_sent++;
        if (last) begin
          thresholds_due.push_back(best_threshold());
          hist_bins = '{default: 0};
          images_sent++;
        end
      end
      @(negedge clk_i);
    end
  endtask

  // One image of the given size; its gray levels cluster around two centres
  // when bimodal, and are spread over the whole range otherwise.
  task automatic send_image(input int unsigned size);
    int unsigned lo_c, hi_c, spread;
    bit          bimodal;
    logic [7:0]  level;
    bimodal = $urandom_range(3) != 0;
    lo_c = $urandom_range(127);
    hi_c = $urandom_range(255, 128);
    spread = $urandom_range(40);
    for (int i = 0; i < size; i++) begin
      if (bimodal) begin
        level = 8'(($urandom_range(1) ? hi_c : lo_c) + $urandom_range(spread));
      end else begin
        level = 8'($urandom);
      end
      send_pixel(level, i == size - 1);
    end
  endtask

  // The sender drops valid and waits until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (thresholds_due.size() != 0) @(negedge clk_i);
  endtask

  // Extremes, a single pixel, flat images, ties and two-level images.
  task automatic test_directed();
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    for (int i = 0; i < 4; i++) send_pixel(8'd128, i == 3);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd20, 1'b0);
    send_pixel(8'd30, 1'b1);
    send_pixel(8'd85, 1'b0);
    send_pixel(8'd170, 1'b0);
    send_pixel(8'd85, 1'b0);
    send_pixel(8'd170, 1'b1);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h0F, 1'b0);
    send_pixel(8'hF0, 1'b1);
    wait_drained();
  endtask

  // Random images, mostly small so that the search stays short; now and
  // then a large one.
  task automatic test_random(input int unsigned n_pixels, input int unsigned s_pct,
                             input int unsigned r_pct);
    int unsigned start;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = pixels_sent;
    while (pixels_sent - start < n_pixels) begin
      send_image(($urandom_range(15) == 0) ? $urandom_range(120, 60)
                                           : $urandom_range(24, 1));
    end
    wait_drained();
  endtask

  // The receiver refuses results for a long stretch while further images
  // arrive, and the input stalls while the back is busy with a search.
  // Afterwards the sender waits until every result has come.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_cycles = 4000;
    for (int i = 0; i < 4; i++) send_image($urandom_range(8, 2));
    wait_drained();
  endtask

  // The receiver drives stall at the falling edge: a long hold first, then
  // random idling.
  always @(negedge clk_i) begin
    if (recv_hold_cycles != 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_idle_pct;
    end
  end

  // Each accepted threshold is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      thresholds_seen++;
      if (thresholds_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected threshold %0d", threshold_o);
      end else begin
        if (threshold_o !== thresholds_due[0]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: threshold expected %0d, got %0d",
                     thresholds_due[0], threshold_o);
        end
        void'(thresholds_due.pop_front());
      end
    end
  end

  // Watchdog: a search on a small image finishes well inside the limit.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    hist_bins = '{default: 0};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(170, 28, 76);
    test_random(170, 76, 28);
    test_backpressure();
    test_random(160, 0, 0);
    wait_drained();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d pixel items in %0d images, %0d thresholds checked,",
             pixels_sent, images_sent, thresholds_seen);
    $display("with random idling on both sides and a long output hold.");
    if (mismatches == 0 && thresholds_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
